FILE: src/mgit_pkg.sv
package mgit_pkg;

    // Fixed field widths
    localparam int unsigned OPND_W    = 31;
    localparam int unsigned LVL_W     = 4;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    // Default for the largest supported subdivision level
    localparam int unsigned MAX_LEVEL_DEF = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LEVEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEVEL  = 1'b1;

    // Control that travels alongside each transaction
    typedef struct packed {
        logic valid;
        logic func;
    } t_ctrl;

    // Function codes
    localparam logic FUNC_MORTON = 1'b0;
    localparam logic FUNC_ROW    = 1'b1;

    // First node index of box-tree level b: (4^(b-1)-1)/3, which is the
    // pattern 0101.. with b-1 set bits; zero for b of zero or one
    function automatic logic [WORD_W-1:0] node_base(input logic [LVL_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int j = 0; j < WORD_W / 2; j++) begin
            r[2*j] = ((j + 1) < int'(b));
        end
        return r;
    endfunction

endpackage

FILE: src/mgit_div_cell.sv
// One restoring division step: shift one dividend bit into the remainder,
// subtract the divisor when it fits and shift the quotient bit in.
module mgit_div_cell #(
    parameter int unsigned REM_W = mgit_pkg::MAX_LEVEL_DEF + 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mgit_pkg::t_ctrl                i_ctrl,
    input  logic [mgit_pkg::OPND_W-1:0]    i_orig,
    input  logic [REM_W-1:0]               i_rem,
    input  logic [mgit_pkg::OPND_W-1:0]    i_work,
    input  logic [REM_W-1:0]               i_divisor,
    output mgit_pkg::t_ctrl                o_ctrl,
    output logic [mgit_pkg::OPND_W-1:0]    o_orig,
    output logic [REM_W-1:0]               o_rem,
    output logic [mgit_pkg::OPND_W-1:0]    o_work
);

    mgit_pkg::t_ctrl                r_ctrl;
    logic [mgit_pkg::OPND_W-1:0]    r_orig;
    logic [REM_W-1:0]               r_rem;
    logic [mgit_pkg::OPND_W-1:0]    r_work;

    logic [REM_W-1:0]               n_rem;
    logic [mgit_pkg::OPND_W-1:0]    n_work;
    logic [REM_W-1:0]               shifted;
    logic                           fits;

    // Remainder stays below the divisor, so its top bit is always clear
    always_comb begin
        shifted = {i_rem[REM_W-2:0], i_work[mgit_pkg::OPND_W-1]};
        fits    = (shifted >= i_divisor);
        n_rem   = fits ? (shifted - i_divisor) : shifted;
        n_work  = {i_work[mgit_pkg::OPND_W-2:0], fits};
    end

    // Control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_orig <= i_orig;
        r_rem  <= n_rem;
        r_work <= n_work;
    end

    assign o_ctrl = r_ctrl;
    assign o_orig = r_orig;
    assign o_rem  = r_rem;
    assign o_work = r_work;

endmodule

FILE: src/mgit_finish.sv
// Two stages after the divider chain: coordinates, Morton code and vertex
// id first, then corner ids and box-tree placement.
module mgit_finish #(
    parameter int unsigned REM_W = mgit_pkg::MAX_LEVEL_DEF + 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mgit_pkg::t_ctrl                 i_ctrl,
    input  logic [mgit_pkg::OPND_W-1:0]     i_orig,
    input  logic [REM_W-1:0]                i_rem,
    input  logic [mgit_pkg::OPND_W-1:0]     i_quot,
    input  logic [mgit_pkg::LVL_W-1:0]      i_grid_lvl,
    input  logic [mgit_pkg::LVL_W-1:0]      i_box_lvl,
    output logic                            o_valid,
    output logic [mgit_pkg::COORD_W-1:0]    o_grid_x,
    output logic [mgit_pkg::COORD_W-1:0]    o_grid_y,
    output logic [mgit_pkg::WORD_W-1:0]     o_morton_index,
    output logic [mgit_pkg::WORD_W-1:0]     o_vertex_index,
    output logic [mgit_pkg::WORD_W-1:0]     o_vertex_right,
    output logic [mgit_pkg::WORD_W-1:0]     o_vertex_down,
    output logic [mgit_pkg::WORD_W-1:0]     o_vertex_down_right,
    output logic [mgit_pkg::WORD_W-1:0]     o_subpatch_index,
    output logic [mgit_pkg::WORD_W-1:0]     o_tree_node,
    output logic [1:0]                      o_box_slot,
    output logic                            o_box_is_root
);

    localparam int unsigned CW = mgit_pkg::COORD_W;
    localparam int unsigned WW = mgit_pkg::WORD_W;

    // Pick the even bits of a word
    function automatic logic [CW-1:0] compact_even(input logic [WW-1:0] v);
        logic [CW-1:0] r;
        for (int i = 0; i < CW; i++) begin
            r[i] = v[2*i];
        end
        return r;
    endfunction

    // x on even bits, y on odd bits
    function automatic logic [WW-1:0] interleave(input logic [CW-1:0] x,
                                                 input logic [CW-1:0] y);
        logic [WW-1:0] r;
        for (int i = 0; i < CW; i++) begin
            r[2*i]   = x[i];
            r[2*i+1] = y[i];
        end
        return r;
    endfunction

    // Stage one
    logic            r_s1_valid;
    logic [CW-1:0]   r_s1_x;
    logic [CW-1:0]   r_s1_y;
    logic [WW-1:0]   r_s1_mort;
    logic [WW-1:0]   r_s1_vtx;

    logic [WW-1:0]   orig32;
    logic [WW-1:0]   x32;
    logic [WW-1:0]   y32;
    logic [WW-1:0]   n_s1_mort;
    logic [WW-1:0]   n_s1_vtx;

    always_comb begin
        orig32 = {1'b0, i_orig};
        unique case (i_ctrl.func)
            mgit_pkg::FUNC_MORTON: begin
                x32       = {{(WW-CW){1'b0}}, compact_even(orig32)};
                y32       = {{(WW-CW){1'b0}}, compact_even(orig32 >> 1)};
                n_s1_mort = orig32;
            end
            mgit_pkg::FUNC_ROW: begin
                x32       = WW'(i_rem);
                y32       = {1'b0, i_quot};
                n_s1_mort = interleave(x32[CW-1:0], y32[CW-1:0]);
            end
            default: begin
                x32       = '0;
                y32       = '0;
                n_s1_mort = '0;
            end
        endcase
        // y * (2^L + 1) + x, the product as a shift and add
        n_s1_vtx = (y32 << i_grid_lvl) + y32 + x32;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x    <= x32[CW-1:0];
        r_s1_y    <= y32[CW-1:0];
        r_s1_mort <= n_s1_mort;
        r_s1_vtx  <= n_s1_vtx;
    end

    // Stage two: corners and box-tree placement
    logic            r_valid;
    logic [CW-1:0]   r_grid_x;
    logic [CW-1:0]   r_grid_y;
    logic [WW-1:0]   r_morton;
    logic [WW-1:0]   r_vtx;
    logic [WW-1:0]   r_vtx_right;
    logic [WW-1:0]   r_vtx_down;
    logic [WW-1:0]   r_vtx_down_right;
    logic [WW-1:0]   r_sub;
    logic [WW-1:0]   r_node;
    logic [1:0]      r_slot;
    logic            r_root;

    logic [WW-1:0]   side;
    logic [4:0]      box_shift;
    logic [WW-1:0]   local_idx;
    logic [WW-1:0]   n_node;
    logic [1:0]      n_slot;
    logic            n_root;

    always_comb begin
        side      = (WW'(1) << i_grid_lvl) + WW'(1);
        box_shift = {i_box_lvl, 1'b0};
        local_idx = r_s1_mort & ~({WW{1'b1}} << box_shift);
        n_root    = (i_box_lvl == '0);
        n_node    = n_root ? '0 : ((local_idx >> 2) + mgit_pkg::node_base(i_box_lvl));
        n_slot    = n_root ? 2'd0 : local_idx[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grid_x         <= r_s1_x;
        r_grid_y         <= r_s1_y;
        r_morton         <= r_s1_mort;
        r_vtx            <= r_s1_vtx;
        r_vtx_right      <= r_s1_vtx + WW'(1);
        r_vtx_down       <= r_s1_vtx + side;
        r_vtx_down_right <= r_s1_vtx + side + WW'(1);
        r_sub            <= r_s1_mort >> box_shift;
        r_node           <= n_node;
        r_slot           <= n_slot;
        r_root           <= n_root;
    end

    assign o_valid             = r_valid;
    assign o_grid_x            = r_grid_x;
    assign o_grid_y            = r_grid_y;
    assign o_morton_index      = r_morton;
    assign o_vertex_index      = r_vtx;
    assign o_vertex_right      = r_vtx_right;
    assign o_vertex_down       = r_vtx_down;
    assign o_vertex_down_right = r_vtx_down_right;
    assign o_subpatch_index    = r_sub;
    assign o_tree_node         = r_node;
    assign o_box_slot          = r_slot;
    assign o_box_is_root       = r_root;

endmodule

FILE: src/morton_grid_index_translator.sv
// Channel   Direction  Transfer condition           Payload
// command   in         i_start & !o_busy            i_func, i_operand
// result    out        o_valid (one cycle strobe)   o_grid_x .. o_box_is_root
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// One command is taken every cycle; o_busy stays low. Each result passes
// through the 31 cells of the restoring divider by 2^L+1, then two
// finishing stages. Results follow command order. Synchronous active-low
// reset clears the valid bits and both levels. The result strobe cannot
// be stalled; config is always ready.
module morton_grid_index_translator #(
    parameter int unsigned MAX_LEVEL = mgit_pkg::MAX_LEVEL_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_func,
    input  logic [mgit_pkg::OPND_W-1:0]         i_operand,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mgit_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mgit_pkg::LVL_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic [mgit_pkg::COORD_W-1:0]        o_grid_x,
    output logic [mgit_pkg::COORD_W-1:0]        o_grid_y,
    output logic [mgit_pkg::WORD_W-1:0]         o_morton_index,
    output logic [mgit_pkg::WORD_W-1:0]         o_vertex_index,
    output logic [mgit_pkg::WORD_W-1:0]         o_vertex_right,
    output logic [mgit_pkg::WORD_W-1:0]         o_vertex_down,
    output logic [mgit_pkg::WORD_W-1:0]         o_vertex_down_right,
    output logic [mgit_pkg::WORD_W-1:0]         o_subpatch_index,
    output logic [mgit_pkg::WORD_W-1:0]         o_tree_node,
    output logic [1:0]                          o_box_slot,
    output logic                                o_box_is_root
);

    localparam int unsigned REM_W     = MAX_LEVEL + 2;
    localparam int unsigned STEPS     = mgit_pkg::OPND_W;
    localparam int unsigned LW        = mgit_pkg::LVL_W;

    // Configuration registers
    logic [LW-1:0] r_grid_level;
    logic [LW-1:0] r_box_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_level <= '0;
            r_box_level  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mgit_pkg::CFG_GRID_LEVEL: r_grid_level <= i_cfg_data;
                mgit_pkg::CFG_BOX_LEVEL:  r_box_level  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    // Saturated levels and divisor 2^L + 1
    logic [LW-1:0]    grid_lvl;
    logic [LW-1:0]    box_lvl;
    logic [REM_W-1:0] divisor;

    always_comb begin
        grid_lvl = (r_grid_level > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : r_grid_level;
        box_lvl  = (r_box_level  > LW'(MAX_LEVEL)) ? LW'(MAX_LEVEL) : r_box_level;
        divisor  = (REM_W'(1) << grid_lvl) + REM_W'(1);
    end

    // Divider chain
    mgit_pkg::t_ctrl                ctrl_c [0:STEPS];
    logic [mgit_pkg::OPND_W-1:0]    orig_c [0:STEPS];
    logic [REM_W-1:0]               rem_c  [0:STEPS];
    logic [mgit_pkg::OPND_W-1:0]    work_c [0:STEPS];

    assign ctrl_c[0] = '{valid: i_start & ~o_busy, func: i_func};
    assign orig_c[0] = i_operand;
    assign rem_c[0]  = '0;
    assign work_c[0] = i_operand;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        mgit_div_cell #(
            .REM_W     (REM_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (ctrl_c[g]),
            .i_orig    (orig_c[g]),
            .i_rem     (rem_c[g]),
            .i_work    (work_c[g]),
            .i_divisor (divisor),
            .o_ctrl    (ctrl_c[g+1]),
            .o_orig    (orig_c[g+1]),
            .o_rem     (rem_c[g+1]),
            .o_work    (work_c[g+1])
        );
    end

    // Finishing stages
    mgit_finish #(
        .REM_W               (REM_W)
    ) u_finish (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctrl              (ctrl_c[STEPS]),
        .i_orig              (orig_c[STEPS]),
        .i_rem               (rem_c[STEPS]),
        .i_quot              (work_c[STEPS]),
        .i_grid_lvl          (grid_lvl),
        .i_box_lvl           (box_lvl),
        .o_valid             (o_valid),
        .o_grid_x            (o_grid_x),
        .o_grid_y            (o_grid_y),
        .o_morton_index      (o_morton_index),
        .o_vertex_index      (o_vertex_index),
        .o_vertex_right      (o_vertex_right),
        .o_vertex_down       (o_vertex_down),
        .o_vertex_down_right (o_vertex_down_right),
        .o_subpatch_index    (o_subpatch_index),
        .o_tree_node         (o_tree_node),
        .o_box_slot          (o_box_slot),
        .o_box_is_root       (o_box_is_root)
    );

endmodule

FILE: tb/tb_morton_grid_index_translator.sv
module tb_morton_grid_index_translator;

    import mgit_pkg::*;

    localparam int unsigned OPND_MAX     = 1073807360;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned RAND_PHASES  = 13;
    localparam int unsigned PHASE_ITEMS  = 100;

    // One result transaction, in port order
    typedef struct packed {
        logic [COORD_W-1:0] grid_x;
        logic [COORD_W-1:0] grid_y;
        logic [WORD_W-1:0]  morton;
        logic [WORD_W-1:0]  vtx;
        logic [WORD_W-1:0]  vtx_right;
        logic [WORD_W-1:0]  vtx_down;
        logic [WORD_W-1:0]  vtx_down_right;
        logic [WORD_W-1:0]  subpatch;
        logic [WORD_W-1:0]  node;
        logic [1:0]         slot;
        logic               root;
    } t_quad_fields;

    // Mirror of the two levels, quad translation and the queue of expected quads
    class t_quad_scoreboard;
        logic [LVL_W-1:0] grid_lvl;
        logic [LVL_W-1:0] box_lvl;
        t_quad_fields     expected_quads[$];
        int               mismatches;

        function new();
            grid_lvl   = '0;
            box_lvl    = '0;
            mismatches = 0;
        endfunction

        function void apply_cfg_write(logic [CFG_IDX_W-1:0] idx, logic [LVL_W-1:0] val);
            if (idx == CFG_GRID_LEVEL)
                grid_lvl = val;
            else if (idx == CFG_BOX_LEVEL)
                box_lvl = val;
        endfunction

        function int pending();
            return expected_quads.size();
        endfunction

        function t_quad_fields translate_quad(logic f, logic [OPND_W-1:0] op);
            logic [WORD_W-1:0] side;
            logic [WORD_W-1:0] col;
            logic [WORD_W-1:0] row;
            logic [WORD_W-1:0] mort;
            logic [WORD_W-1:0] vtx;
            logic [WORD_W-1:0] local_bits;
            logic [WORD_W-1:0] base;
            int unsigned       blv;
            t_quad_fields      r;
            side = (32'd1 << grid_lvl) + 32'd1;
            blv  = 32'(box_lvl);
            col  = '0;
            row  = '0;
            mort = '0;
            if (f == FUNC_MORTON) begin
                // de-interleave: x from even bits, y from odd bits
                mort = {1'b0, op};
                for (int i = 0; i < 16; i++) begin
                    col[i] = mort[2*i];
                    row[i] = mort[2*i+1];
                end
            end else begin
                // row-major id; full quotient kept for vertex math
                col = {1'b0, op} % side;
                row = {1'b0, op} / side;
                for (int i = 0; i < 16; i++) begin
                    mort[2*i]   = col[i];
                    mort[2*i+1] = row[i];
                end
            end
            vtx              = row * side + col;
            r.grid_x         = col[COORD_W-1:0];
            r.grid_y         = row[COORD_W-1:0];
            r.morton         = mort;
            r.vtx            = vtx;
            r.vtx_right      = vtx + 32'd1;
            r.vtx_down       = vtx + side;
            r.vtx_down_right = vtx + side + 32'd1;
            r.subpatch       = mort >> (2 * blv);
            if (blv == 0) begin
                r.node = '0;
                r.slot = '0;
                r.root = 1'b1;
            end else begin
                local_bits = mort & ~(32'hFFFF_FFFF << (2 * blv));
                base       = ((32'd1 << (2 * (blv - 1))) - 32'd1) / 32'd3;
                r.node     = (local_bits >> 2) + base;
                r.slot     = local_bits[1:0];
                r.root     = 1'b0;
            end
            return r;
        endfunction

        function void note_command(logic f, logic [OPND_W-1:0] op);
            expected_quads.push_back(translate_quad(f, op));
        endfunction

        function void field_check(string name, logic [WORD_W-1:0] exp_v,
                                  logic [WORD_W-1:0] act_v);
            if (act_v !== exp_v) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch %s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_quad_fields act);
            t_quad_fields e;
            if (expected_quads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction, morton 0x%08h", act.morton);
                return;
            end
            e = expected_quads.pop_front();
            field_check("grid_x", 32'(e.grid_x), 32'(act.grid_x));
            field_check("grid_y", 32'(e.grid_y), 32'(act.grid_y));
            field_check("morton_index", e.morton, act.morton);
            field_check("vertex_index", e.vtx, act.vtx);
            field_check("vertex_right", e.vtx_right, act.vtx_right);
            field_check("vertex_down", e.vtx_down, act.vtx_down);
            field_check("vertex_down_right", e.vtx_down_right, act.vtx_down_right);
            field_check("subpatch_index", e.subpatch, act.subpatch);
            field_check("tree_node", e.node, act.node);
            field_check("box_slot", 32'(e.slot), 32'(act.slot));
            field_check("box_is_root", 32'(e.root), 32'(act.root));
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic                 i_func;
    logic [OPND_W-1:0]    i_operand;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LVL_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [COORD_W-1:0]   o_grid_x;
    logic [COORD_W-1:0]   o_grid_y;
    logic [WORD_W-1:0]    o_morton_index;
    logic [WORD_W-1:0]    o_vertex_index;
    logic [WORD_W-1:0]    o_vertex_right;
    logic [WORD_W-1:0]    o_vertex_down;
    logic [WORD_W-1:0]    o_vertex_down_right;
    logic [WORD_W-1:0]    o_subpatch_index;
    logic [WORD_W-1:0]    o_tree_node;
    logic [1:0]           o_box_slot;
    logic                 o_box_is_root;

    t_quad_scoreboard sb = new();

    morton_grid_index_translator DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_start),
        .o_busy              (o_busy),
        .i_func              (i_func),
        .i_operand           (i_operand),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_valid             (o_valid),
        .o_grid_x            (o_grid_x),
        .o_grid_y            (o_grid_y),
        .o_morton_index      (o_morton_index),
        .o_vertex_index      (o_vertex_index),
        .o_vertex_right      (o_vertex_right),
        .o_vertex_down       (o_vertex_down),
        .o_vertex_down_right (o_vertex_down_right),
        .o_subpatch_index    (o_subpatch_index),
        .o_tree_node         (o_tree_node),
        .o_box_slot          (o_box_slot),
        .o_box_is_root       (o_box_is_root)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Monitor: config writes, accepted commands and result transactions
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.apply_cfg_write(i_cfg_index, i_cfg_data);
            if (i_start && !o_busy)
                sb.note_command(i_func, i_operand);
            if (o_valid)
                sb.check_result({o_grid_x, o_grid_y, o_morton_index, o_vertex_index,
                                 o_vertex_right, o_vertex_down, o_vertex_down_right,
                                 o_subpatch_index, o_tree_node, o_box_slot,
                                 o_box_is_root});
        end
    end

    // Hold start high until the command transaction is taken; start stays up
    task automatic send_command(input logic f, input logic [OPND_W-1:0] op);
        i_start   <= 1'b1;
        i_func    <= f;
        i_operand <= op;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Random sender gap: mostly none or short, now and then long
    task automatic pause_sender(input bit quiet);
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            n = 0;
        else if (r < 85)
            n = $urandom_range(1, 3);
        else if (r < 97)
            n = $urandom_range(4, 10);
        else
            n = $urandom_range(20, 60);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue(input logic f, input logic [OPND_W-1:0] op, input bit quiet);
        send_command(f, op);
        pause_sender(quiet);
    endtask

    // Stop sending and wait until every expected quad has come back
    task automatic drain_results();
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One config transaction, then valid is lowered and the channel left idle before returning
    task automatic write_level(input logic [CFG_IDX_W-1:0] idx, input logic [LVL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_levels(input logic [LVL_W-1:0] g, input logic [LVL_W-1:0] b);
        drain_results();
        write_level(CFG_GRID_LEVEL, g);
        write_level(CFG_BOX_LEVEL, b);
    endtask

    // Operand mix: in-grid quads, anywhere in range, and boundary values
    function automatic logic [OPND_W-1:0] pick_operand(input logic f);
        logic [WORD_W-1:0] side;
        logic [WORD_W-1:0] v;
        int                sel;
        int                k;
        side = (32'd1 << sb.grid_lvl) + 32'd1;
        sel  = $urandom_range(0, 99);
        k    = $urandom_range(0, 30);
        if (sel < 50) begin
            if (f == FUNC_MORTON)
                v = $urandom & ((32'd1 << (2 * sb.grid_lvl)) - 32'd1);
            else
                v = $urandom_range(0, side * side - 32'd1);
        end else if (sel < 80) begin
            v = $urandom_range(0, OPND_MAX);
        end else begin
            case ($urandom_range(0, 6))
                0:       v = 32'd0;
                1:       v = OPND_MAX;
                2:       v = 32'd1 << (k % 30);
                3:       v = (32'd1 << k) - 32'd1;
                4:       v = side - 32'd1;
                5:       v = side;
                default: v = side * side - 32'd1;
            endcase
            if (v > OPND_MAX)
                v = OPND_MAX;
        end
        return v[OPND_W-1:0];
    endfunction

    // Watchdog
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial begin
        logic [LVL_W-1:0] g;
        logic [LVL_W-1:0] b;
        logic             f;
        bit               quiet;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_func      <= FUNC_MORTON;
        i_operand   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GRID_LEVEL;
        i_cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset levels: one-quad-wide grid, root box; large rows wrap grid_y
        issue(FUNC_MORTON, 31'd0, 1'b0);
        issue(FUNC_MORTON, OPND_W'(OPND_MAX), 1'b0);
        issue(FUNC_MORTON, 31'h2AAA_AAAA, 1'b0);
        issue(FUNC_MORTON, 31'h1555_5555, 1'b0);
        issue(FUNC_ROW, 31'd0, 1'b0);
        issue(FUNC_ROW, 31'd1, 1'b0);
        issue(FUNC_ROW, 31'd2, 1'b0);
        issue(FUNC_ROW, OPND_W'(OPND_MAX), 1'b0);

        // Mid levels: grid edges and operands outside the grid
        set_levels(4'd4, 4'd2);
        issue(FUNC_ROW, 31'd16, 1'b1);
        issue(FUNC_ROW, 31'd17, 1'b1);
        issue(FUNC_ROW, 31'd288, 1'b1);
        issue(FUNC_ROW, 31'd289, 1'b1);
        issue(FUNC_MORTON, 31'd255, 1'b1);
        issue(FUNC_MORTON, 31'd256, 1'b1);
        issue(FUNC_MORTON, 31'h4000_0000, 1'b1);
        issue(FUNC_ROW, 31'h3FFF_FFFF, 1'b1);

        // Top levels
        set_levels(4'd15, 4'd15);
        issue(FUNC_MORTON, 31'h3FFF_FFFF, 1'b0);
        issue(FUNC_MORTON, OPND_W'(OPND_MAX), 1'b0);
        issue(FUNC_ROW, OPND_W'(OPND_MAX), 1'b0);
        issue(FUNC_ROW, 31'd32768, 1'b0);
        issue(FUNC_ROW, 31'd32769, 1'b0);

        // Random phases; the first four sweep the level extremes
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       begin g = 4'd0;  b = 4'd0;  end
                1:       begin g = 4'd15; b = 4'd15; end
                2:       begin g = 4'd0;  b = 4'd15; end
                3:       begin g = 4'd15; b = 4'd0;  end
                default: begin
                    g = LVL_W'($urandom_range(0, 15));
                    b = LVL_W'($urandom_range(0, 15));
                end
            endcase
            set_levels(g, b);
            quiet = (p % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                f = $urandom_range(0, 1) ? FUNC_ROW : FUNC_MORTON;
                issue(f, pick_operand(f), quiet);
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
